// ===== rtl/cra_pkg.sv =====
// Shared types, codes and the per-opcode micro-program of the rational arithmetic unit.
package cra_pkg;

  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned DEN_BITS  = 63;
  localparam int unsigned PC_BITS   = 5;

  typedef enum logic [1:0] {
    OP_NORM = 2'd0,
    OP_ADD  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NEG  = 2'd3
  } opcode_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DEN = 2'd2;

  typedef enum logic [4:0] {
    U_CHK0, U_CHK1,
    U_G_N0D0, U_G_N1D1, U_G_N0D1, U_G_N1D0, U_G_D0D1,
    U_DIV_N0, U_DIV_D0, U_DIV_N1, U_DIV_D1, U_DIV_TD0,
    U_MUL_N0N1, U_MUL_D0D1, U_MUL_N0D1, U_MUL_N1T,
    U_ADD, U_NEG, U_END
  } uop_e;

  typedef enum logic [2:0] {
    K_CHK, K_GCD, K_DIV, K_MUL, K_ADD, K_NEG, K_END
  } kind_e;

  typedef enum logic [2:0] {
    R_N0, R_D0, R_N1, R_D1, R_T
  } sel_e;

  typedef struct packed {
    kind_e kind;
    sel_e  xsel;
    sel_e  ysel;
    sel_e  dsel;
  } uop_t;

  // Micro-program: steps of each opcode, in the order their errors take priority.
  function automatic uop_e prog_at(opcode_e op, logic [PC_BITS-1:0] pc);
    uop_e u;
    u = U_END;
    if (op == OP_NEG) begin
      u = (pc == '0) ? U_NEG : U_END;
    end else begin
      case (pc)
        5'd0:  u = U_CHK0;
        5'd1:  u = U_G_N0D0;
        5'd2:  u = U_DIV_N0;
        5'd3:  u = U_DIV_D0;
        5'd4:  u = (op == OP_NORM) ? U_END : U_CHK1;
        5'd5:  u = U_G_N1D1;
        5'd6:  u = U_DIV_N1;
        5'd7:  u = U_DIV_D1;
        5'd8:  u = (op == OP_MUL) ? U_G_N0D1   : U_G_D0D1;
        5'd9:  u = (op == OP_MUL) ? U_DIV_N0   : U_DIV_D1;
        5'd10: u = (op == OP_MUL) ? U_DIV_D1   : U_DIV_TD0;
        5'd11: u = (op == OP_MUL) ? U_G_N1D0   : U_MUL_N0D1;
        5'd12: u = (op == OP_MUL) ? U_DIV_N1   : U_MUL_N1T;
        5'd13: u = (op == OP_MUL) ? U_DIV_D0   : U_MUL_D0D1;
        5'd14: u = (op == OP_MUL) ? U_MUL_N0N1 : U_ADD;
        5'd15: u = (op == OP_MUL) ? U_MUL_D0D1 : U_G_N0D0;
        5'd16: u = (op == OP_MUL) ? U_G_N0D0   : U_DIV_N0;
        5'd17: u = (op == OP_MUL) ? U_DIV_N0   : U_DIV_D0;
        5'd18: u = (op == OP_MUL) ? U_DIV_D0   : U_END;
        default: u = U_END;
      endcase
    end
    return u;
  endfunction

  function automatic uop_t uop_dec(uop_e u);
    uop_t d;
    d = '{kind: K_END, xsel: R_N0, ysel: R_N0, dsel: R_N0};
    unique case (u)
      U_CHK0:     d = '{K_CHK, R_D0, R_D0, R_D0};
      U_CHK1:     d = '{K_CHK, R_D1, R_D1, R_D1};
      U_G_N0D0:   d = '{K_GCD, R_N0, R_D0, R_N0};
      U_G_N1D1:   d = '{K_GCD, R_N1, R_D1, R_N1};
      U_G_N0D1:   d = '{K_GCD, R_N0, R_D1, R_N0};
      U_G_N1D0:   d = '{K_GCD, R_N1, R_D0, R_N1};
      U_G_D0D1:   d = '{K_GCD, R_D0, R_D1, R_D0};
      U_DIV_N0:   d = '{K_DIV, R_N0, R_N0, R_N0};
      U_DIV_D0:   d = '{K_DIV, R_D0, R_D0, R_D0};
      U_DIV_N1:   d = '{K_DIV, R_N1, R_N1, R_N1};
      U_DIV_D1:   d = '{K_DIV, R_D1, R_D1, R_D1};
      U_DIV_TD0:  d = '{K_DIV, R_D0, R_D0, R_T};
      U_MUL_N0N1: d = '{K_MUL, R_N0, R_N1, R_N0};
      U_MUL_D0D1: d = '{K_MUL, R_D0, R_D1, R_D0};
      U_MUL_N0D1: d = '{K_MUL, R_N0, R_D1, R_N0};
      U_MUL_N1T:  d = '{K_MUL, R_N1, R_T,  R_N1};
      U_ADD:      d = '{K_ADD, R_N0, R_N1, R_N0};
      U_NEG:      d = '{K_NEG, R_N0, R_N0, R_N0};
      U_END:      d = '{K_END, R_N0, R_N0, R_N0};
      default:    d = '{K_END, R_N0, R_N0, R_N0};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/cra_in_if.sv =====
// Input channel: opcode and two fractions, valid/ready handshake.
interface cra_in_if;
  import cra_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic signed [DATA_BITS-1:0] a_num;
  logic signed [DATA_BITS-1:0] a_den;
  logic signed [DATA_BITS-1:0] b_num;
  logic signed [DATA_BITS-1:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== rtl/cra_out_if.sv =====
// Output channel: reduced fraction and status, valid/ready handshake.
interface cra_out_if;
  import cra_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] res_num;
  logic [DEN_BITS-1:0]         res_den;
  logic [1:0]                  status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== rtl/checked_rational_arithmetic_unit.sv =====
// Checked rational ALU: micro-sequenced gcd, divide and multiply on one shared shift/add unit.
//
//  channel | dir | payload                              | handshake
//  in_i    | in  | opcode, a_num, a_den, b_num, b_den   | valid/ready
//  out_o   | out | res_num, res_den, status             | valid/ready
//
// Every divide or multiply runs WORD_BITS steps of the shared adder, issued from and
// completed in the S_EXEC state; each gcd remainder step is one such divide.
// Negate runs no gcd; otherwise the run time of an item is set by the number of gcd
// remainder steps (a multiply runs five gcds).
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// in_i.ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next transaction is taken while it waits.
module checked_rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  cra_in_if.sink    in_i,
  cra_out_if.source out_o
);
  import cra_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] SignBit = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] MaxMag  = ~SignBit;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [PC_BITS-1:0]   pc_q, pc_d;
  opcode_e              op_q, op_d;
  logic                 gcd_run_q, gcd_run_d;
  logic                 done_q, done_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           st_q, st_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic [WORD_BITS-1:0] n0_q, n0_d, d0_q, d0_d, n1_q, n1_d, d1_q, d1_d, t_q, t_d;
  logic                 sn0_q, sn0_d, sd0_q, sd0_d, sn1_q, sn1_d, sd1_q, sd1_d;
  logic [WORD_BITS-1:0] g_q, g_d, gy_q, gy_d;
  logic [WORD_BITS-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;

  logic signed [DATA_BITS-1:0] res_num_q, res_num_d;
  logic [DEN_BITS-1:0]         res_den_q, res_den_d;
  logic [1:0]                  res_st_q, res_st_d;

  function automatic logic [WORD_BITS-1:0] mag_of(logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  uop_t u;
  assign u = uop_dec(prog_at(op_q, pc_q));

  // Operand select
  logic [WORD_BITS-1:0] xm, ym;
  logic                 xs, ys;
  always_comb begin
    unique case (u.xsel)
      R_N0:    begin xm = n0_q; xs = sn0_q; end
      R_D0:    begin xm = d0_q; xs = sd0_q; end
      R_N1:    begin xm = n1_q; xs = sn1_q; end
      R_D1:    begin xm = d1_q; xs = sd1_q; end
      default: begin xm = t_q;  xs = 1'b0;  end
    endcase
    unique case (u.ysel)
      R_N0:    begin ym = n0_q; ys = sn0_q; end
      R_D0:    begin ym = d0_q; ys = sd0_q; end
      R_N1:    begin ym = n1_q; ys = sn1_q; end
      R_D1:    begin ym = d1_q; ys = sd1_q; end
      default: begin ym = t_q;  ys = 1'b0;  end
    endcase
  end

  // Shared adder: restoring divide step or shift-add multiply step
  logic                 div_mode;
  logic [WORD_BITS:0]   rs;
  logic [WORD_BITS+1:0] add_a, add_b, add_s;
  logic [WORD_BITS:0]   mul_sum;
  assign div_mode = (state_q == S_DIV);
  assign rs       = {rem_q, quo_q[WORD_BITS-1]};
  assign add_a    = div_mode ? {1'b0, rs} : {2'b00, rem_q};
  assign add_b    = div_mode ? ~{2'b00, dvs_q} : {2'b00, dvs_q};
  assign add_s    = add_a + add_b + {{(WORD_BITS+1){1'b0}}, div_mode};
  assign mul_sum  = quo_q[0] ? add_s[WORD_BITS:0] : {1'b0, rem_q};

  // Product check
  logic                 mul_neg, mul_ovf;
  logic [WORD_BITS-1:0] mul_lim;
  assign mul_neg = xs ^ ys;
  assign mul_lim = mul_neg ? SignBit : MaxMag;
  assign mul_ovf = (rem_q != '0) || (quo_q > mul_lim);

  // Checked signed add of n0 and n1
  logic [WORD_BITS:0]   sum_w;
  logic [WORD_BITS-1:0] add_m, add_lim;
  logic                 add_sg, add_ovf;
  assign sum_w   = {1'b0, n0_q} + {1'b0, n1_q};
  assign add_lim = sn0_q ? SignBit : MaxMag;
  always_comb begin
    add_ovf = 1'b0;
    add_m   = n0_q;
    add_sg  = sn0_q;
    if (n0_q == '0) begin
      add_m  = n1_q;
      add_sg = sn1_q;
    end else if (n1_q == '0) begin
      add_m  = n0_q;
      add_sg = sn0_q;
    end else if (sn0_q == sn1_q) begin
      add_ovf = sum_w > {1'b0, add_lim};
      add_m   = sum_w[WORD_BITS-1:0];
      add_sg  = sn0_q;
    end else if (n0_q >= n1_q) begin
      add_m  = n0_q - n1_q;
      add_sg = (add_m != '0) && sn0_q;
    end else begin
      add_m  = n1_q - n0_q;
      add_sg = sn1_q;
    end
  end

  // Result encoding
  logic [WORD_BITS-1:0] num_enc, den_enc;
  assign num_enc = (sn0_q && n0_q != '0) ? (~n0_q + 1'b1) : n0_q;
  assign den_enc = sd0_q ? (~d0_q + 1'b1) : d0_q;

  logic                 wr;
  logic [WORD_BITS-1:0] wr_m;
  logic                 wr_s;
  logic signed [DATA_BITS-1:0] den_ext;
  assign den_ext = DATA_BITS'(signed'(den_enc));

  always_comb begin
    state_d = state_q;  pc_d = pc_q;  op_d = op_q;
    gcd_run_d = gcd_run_q;  done_d = done_q;  st_d = st_q;  cnt_d = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    n0_d = n0_q;  d0_d = d0_q;  n1_d = n1_q;  d1_d = d1_q;  t_d = t_q;
    sn0_d = sn0_q;  sd0_d = sd0_q;  sn1_d = sn1_q;  sd1_d = sd1_q;
    g_d = g_q;  gy_d = gy_q;  rem_d = rem_q;  quo_d = quo_q;  dvs_d = dvs_q;
    res_num_d = res_num_q;  res_den_d = res_den_q;  res_st_d = res_st_q;
    wr = 1'b0;  wr_m = quo_q;  wr_s = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d      = opcode_e'(in_i.opcode);
          n0_d      = mag_of(in_i.a_num[WORD_BITS-1:0]);
          sn0_d     = in_i.a_num[WORD_BITS-1];
          d0_d      = mag_of(in_i.a_den[WORD_BITS-1:0]);
          sd0_d     = in_i.a_den[WORD_BITS-1];
          n1_d      = mag_of(in_i.b_num[WORD_BITS-1:0]);
          sn1_d     = in_i.b_num[WORD_BITS-1];
          d1_d      = mag_of(in_i.b_den[WORD_BITS-1:0]);
          sd1_d     = in_i.b_den[WORD_BITS-1];
          pc_d      = '0;
          gcd_run_d = 1'b0;
          done_d    = 1'b0;
          st_d      = ST_OK;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (u.kind)
          K_CHK: begin
            if (xs || xm == '0) begin
              st_d    = ST_DEN;
              state_d = S_FIN;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          K_GCD: begin
            if (!gcd_run_q) begin
              g_d       = xm;
              gy_d      = ym;
              gcd_run_d = 1'b1;
            end else if (done_q) begin
              g_d    = gy_q;
              gy_d   = rem_q;
              done_d = 1'b0;
            end else if (gy_q == '0) begin
              gcd_run_d = 1'b0;
              pc_d      = pc_q + 1'b1;
            end else begin
              rem_d   = '0;
              quo_d   = g_q;
              dvs_d   = gy_q;
              cnt_d   = '0;
              state_d = S_DIV;
            end
          end
          K_DIV: begin
            if (done_q) begin
              wr     = 1'b1;
              wr_m   = quo_q;
              wr_s   = xs;
              done_d = 1'b0;
              pc_d   = pc_q + 1'b1;
            end else begin
              rem_d   = '0;
              quo_d   = xm;
              dvs_d   = g_q;
              cnt_d   = '0;
              state_d = S_DIV;
            end
          end
          K_MUL: begin
            if (done_q) begin
              done_d = 1'b0;
              if (mul_ovf) begin
                st_d    = ST_OVF;
                state_d = S_FIN;
              end else begin
                wr   = 1'b1;
                wr_m = quo_q;
                wr_s = mul_neg && (quo_q != '0);
                pc_d = pc_q + 1'b1;
              end
            end else begin
              rem_d   = '0;
              quo_d   = xm;
              dvs_d   = ym;
              cnt_d   = '0;
              state_d = S_MUL;
            end
          end
          K_ADD: begin
            if (add_ovf) begin
              st_d    = ST_OVF;
              state_d = S_FIN;
            end else begin
              n0_d  = add_m;
              sn0_d = add_sg;
              pc_d  = pc_q + 1'b1;
            end
          end
          K_NEG: begin
            if (sn0_q && n0_q == SignBit) begin
              st_d    = ST_OVF;
              state_d = S_FIN;
            end else begin
              sn0_d = !sn0_q;
              pc_d  = pc_q + 1'b1;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_DIV: begin
        rem_d = add_s[WORD_BITS+1] ? rs[WORD_BITS-1:0] : add_s[WORD_BITS-1:0];
        quo_d = {quo_q[WORD_BITS-2:0], ~add_s[WORD_BITS+1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WORD_BITS - 1)) begin
          done_d  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_MUL: begin
        rem_d = mul_sum[WORD_BITS:1];
        quo_d = {mul_sum[0], quo_q[WORD_BITS-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WORD_BITS - 1)) begin
          done_d  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          if (st_q == ST_OK) begin
            res_num_d = DATA_BITS'(signed'(num_enc));
            res_den_d = den_ext[DEN_BITS-1:0];
          end else begin
            res_num_d = '0;
            res_den_d = '0;
          end
          res_st_d    = st_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (wr) begin
      unique case (u.dsel)
        R_N0:    begin n0_d = wr_m; sn0_d = wr_s; end
        R_D0:    begin d0_d = wr_m; sd0_d = wr_s; end
        R_N1:    begin n1_d = wr_m; sn1_d = wr_s; end
        R_D1:    begin d1_d = wr_m; sd1_d = wr_s; end
        default: t_d = wr_m;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      op_q        <= OP_NORM;
      gcd_run_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= ST_OK;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      op_q        <= op_d;
      gcd_run_q   <= gcd_run_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q  <= n0_d;   d0_q  <= d0_d;   n1_q  <= n1_d;   d1_q  <= d1_d;   t_q <= t_d;
    sn0_q <= sn0_d;  sd0_q <= sd0_d;  sn1_q <= sn1_d;  sd1_q <= sd1_d;
    g_q   <= g_d;    gy_q  <= gy_d;
    rem_q <= rem_d;  quo_q <= quo_d;  dvs_q <= dvs_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_st_q  <= res_st_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = res_num_q;
  assign out_o.res_den = res_den_q;
  assign out_o.status  = res_st_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> (out_o.res_num == '0 && out_o.res_den == '0))
    else $error("error result carries nonzero fraction");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready while a transaction is in progress");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL) |-> (cnt_q < CntW'(WORD_BITS)))
    else $error("shared unit step count out of range");

  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == S_DIV || $past(state_q) == S_MUL))
    else $error("unit completion without a unit run");

endmodule
